// ===== rtl/core/salc_pkg.sv =====
// Shared types and codes for the set-associative LRU cache model.
// No dependencies; salc_repl, the top level and salc_chk import this package.
`timescale 1ns / 1ps

package salc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_SECOND
  } state_t;

  // Lookup status handed from the replacement logic to the controller.
  typedef struct packed {
    logic hit;
    logic evict;
  } salc_status_t;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

endpackage

// ===== rtl/core/salc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/salc_repl.sv =====
// Way lookup and LRU update for one set row read from the tag and meta RAMs.
// Depends on salc_pkg for the status struct.
`timescale 1ns / 1ps

module salc_repl
  import salc_pkg::*;
#(
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 32
) (
  input  logic [WAYS*TAG_WIDTH-1:0]                        tag_row,
  input  logic [WAYS*((WAYS > 1 ? $clog2(WAYS) : 1)+1)-1:0] meta_row,
  input  logic [TAG_WIDTH-1:0]                             tag,
  input  logic [$clog2(WAYS+1)-1:0]                        nways,
  output logic [WAYS*TAG_WIDTH-1:0]                        tag_row_new,
  output logic [WAYS*((WAYS > 1 ? $clog2(WAYS) : 1)+1)-1:0] meta_row_new,
  output salc_status_t                                     status
);

  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  logic [WAYS-1:0][TAG_WIDTH-1:0] tags;
  logic [WAYS-1:0][TAG_WIDTH-1:0] tags_new;
  logic [WAYS-1:0][RANK_W-1:0]    ranks;
  logic [WAYS-1:0][RANK_W-1:0]    ranks_new;
  logic [WAYS-1:0]                valid;
  logic [WAYS-1:0]                valid_new;
  logic [WAYS-1:0]                active;

  logic              hit;
  logic              free;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  vic_way;
  logic [WAY_W-1:0]  sel_way;
  logic [RANK_W-1:0] best;
  logic [RANK_W-1:0] old_rank;

  assign tags  = tag_row;
  assign ranks = meta_row[WAYS*RANK_W-1:0];
  assign valid = meta_row[WAYS*RANK_W +: WAYS];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      active[i] = NW_W'(i) < nways;
    end

    // lowest matching way wins; a miss takes the lowest free way, else the victim
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && active[i] && valid[i] && tags[i] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!free && active[i] && !valid[i]) begin
        free     = 1'b1;
        free_way = WAY_W'(i);
      end
    end

    // victim: lowest way among those of highest rank
    best    = ranks[0];
    vic_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (active[i] && ranks[i] > best) begin
        best    = ranks[i];
        vic_way = WAY_W'(i);
      end
    end

    sel_way  = hit ? hit_way : (free ? free_way : vic_way);
    old_rank = ranks[hit_way];

    tags_new  = tags;
    valid_new = valid;
    if (!hit) begin
      tags_new[sel_way]  = tag;
      valid_new[sel_way] = 1'b1;
    end

    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == sel_way) begin
        ranks_new[i] = '0;
      end else if (active[i] && valid[i] && (!hit || ranks[i] < old_rank) &&
                   ranks[i] < RANK_MAX) begin
        ranks_new[i] = ranks[i] + RANK_W'(1);
      end else begin
        ranks_new[i] = ranks[i];
      end
    end

    status.hit   = hit;
    status.evict = !hit && !free;
  end

  assign tag_row_new  = tags_new;
  assign meta_row_new = {valid_new, ranks_new};

endmodule

// ===== rtl/core/set_associative_lru_cache_sim.sv =====
// Set-associative cache with LRU replacement: top level, controller and counters.
// First result word is registered at out_* after the set RAM read, once out_* is free.
// A request is taken only in ST_IDLE, after the tag/valid/rank write-back of the last one
// and a modify's second word. Reset (rst_n low, synchronous) resets counters and config,
// then zeroes valid bits and ranks of 2**MAX_SET_BITS sets (64 by default), in_ready low.
`timescale 1ns / 1ps

module set_associative_lru_cache_sim
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int TAG_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_evict_total,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int NSETS     = 1 << MAX_SET_BITS;
  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W      = $clog2(WAYS + 1);
  localparam int META_W    = WAYS * (RANK_W + 1);
  localparam int TROW_W    = WAYS * TAG_WIDTH;
  localparam logic [3:0] SB_MAX = 4'(MAX_SET_BITS);
  localparam logic [4:0] WAYS_MAX = 5'(WAYS);
  localparam logic [SET_IDX_W-1:0] CLR_LAST = SET_IDX_W'(NSETS - 1);

  state_t state_r, state_nxt;

  logic [2:0] set_bits_r;
  logic [5:0] blk_bits_r;
  logic [3:0] ways_r;

  logic [SET_IDX_W-1:0] clr_cnt_r;
  logic [SET_IDX_W-1:0] set_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic                 mod_r;

  logic [31:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [31:0] hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;

  logic        out_valid_r;
  outcome_t    out_outcome_r;
  logic [31:0] out_hit_r, out_miss_r, out_evict_r;
  logic        out_last_r;

  // address split
  logic [3:0]           sb_eff;
  logic [6:0]           tag_shift;
  logic [63:0]          set_shifted;
  logic [63:0]          tag_shifted;
  logic [SET_IDX_W-1:0] set_mask;
  logic [SET_IDX_W-1:0] set_calc;
  logic [TAG_WIDTH-1:0] tag_calc;
  logic [4:0]           nways5;
  logic [NW_W-1:0]      nways;

  logic accept;
  logic out_free;
  logic ld_first;
  logic ld_second;
  logic meta_we;
  logic tag_we;
  logic [SET_IDX_W-1:0] meta_wa;
  logic [META_W-1:0]    meta_wd;

  logic [TROW_W-1:0] tag_rd, tag_new;
  logic [META_W-1:0] meta_rd, meta_new;
  salc_status_t      status;
  outcome_t          first_outcome;

  assign sb_eff      = ({1'b0, set_bits_r} > SB_MAX) ? SB_MAX : {1'b0, set_bits_r};
  assign tag_shift   = 7'(sb_eff) + 7'(blk_bits_r);
  assign set_shifted = in_address >> blk_bits_r;
  assign tag_shifted = in_address >> tag_shift[5:0];
  assign set_mask    = ~({SET_IDX_W{1'b1}} << sb_eff);
  assign set_calc    = set_shifted[SET_IDX_W-1:0] & set_mask;
  // tag is zero once the split covers the whole address
  assign tag_calc    = tag_shift[6] ? '0 : tag_shifted[TAG_WIDTH-1:0];

  assign nways5 = (ways_r == 4'd0) ? 5'd1 :
                  ({1'b0, ways_r} > WAYS_MAX) ? WAYS_MAX : {1'b0, ways_r};
  assign nways  = NW_W'(nways5);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  salc_ram #(
    .WIDTH (TROW_W),
    .DEPTH (NSETS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (set_r),
    .wr_data (tag_new),
    .rd_en   (accept),
    .rd_addr (set_calc),
    .rd_data (tag_rd)
  );

  salc_ram #(
    .WIDTH (META_W),
    .DEPTH (NSETS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wa),
    .wr_data (meta_wd),
    .rd_en   (accept),
    .rd_addr (set_calc),
    .rd_data (meta_rd)
  );

  salc_repl #(
    .WAYS      (WAYS),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_repl (
    .tag_row      (tag_rd),
    .meta_row     (meta_rd),
    .tag          (tag_r),
    .nways        (nways),
    .tag_row_new  (tag_new),
    .meta_row_new (meta_new),
    .status       (status)
  );

  assign first_outcome = status.hit ? OUT_HIT : (status.evict ? OUT_EVICT : OUT_FILL);

  always_comb begin
    state_nxt = state_r;
    ld_first  = 1'b0;
    ld_second = 1'b0;
    meta_we   = 1'b0;
    tag_we    = 1'b0;
    meta_wa   = set_r;
    meta_wd   = meta_new;
    unique case (state_r)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_cnt_r;
        meta_wd = '0;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_command != CMD_NONE) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // write-back only once the output register can take the word
        if (out_free) begin
          ld_first  = 1'b1;
          meta_we   = 1'b1;
          tag_we    = !status.hit;
          state_nxt = mod_r ? ST_SECOND : ST_IDLE;
        end
      end
      ST_SECOND: begin
        // second access of a modify always hits the line just touched, at rank 0
        if (out_free) begin
          ld_second = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign hit_cnt_nxt   = hit_cnt_r + {31'b0, (ld_first && status.hit) || ld_second};
  assign miss_cnt_nxt  = miss_cnt_r + {31'b0, ld_first && !status.hit};
  assign evict_cnt_nxt = evict_cnt_r + {31'b0, ld_first && status.evict};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r  <= SET_BITS_RST;
      blk_bits_r  <= BLOCK_BITS_RST;
      ways_r      <= WAYS_RST;
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits_r <= cfg_wdata[2:0];
          CFG_BLOCK_BITS: blk_bits_r <= cfg_wdata;
          CFG_WAYS:       ways_r     <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_IDX_W'(1);
      end
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      if (ld_first || ld_second) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_calc;
      tag_r <= tag_calc;
      mod_r <= (in_command == CMD_MODIFY);
    end
    if (ld_first || ld_second) begin
      out_outcome_r <= ld_second ? OUT_HIT : first_outcome;
      out_hit_r     <= hit_cnt_nxt;
      out_miss_r    <= miss_cnt_nxt;
      out_evict_r   <= evict_cnt_nxt;
      out_last_r    <= ld_second || !mod_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_hit_total   = out_hit_r;
  assign out_miss_total  = out_miss_r;
  assign out_evict_total = out_evict_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/salc_chk.sv =====
// Port-level checker for the LRU cache top level, bound in below.
// Depends on salc_pkg for the outcome codes.
`timescale 1ns / 1ps

module salc_chk
  import salc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_outcome,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_miss_total,
  input logic        out_last
);

  // reset empties the output and holds off input during the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input open right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_total) && $stable(out_last))
    else $error("result word changed while stalled");

  // first word of a modify is followed at once by a hit that ends the item
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_last && out_outcome == OUT_HIT)
    else $error("modify second word missing or not a hit");

  a_pair_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_hit_total == $past(out_hit_total) + 32'd1 && $stable(out_miss_total))
    else $error("modify second word counts wrong");

endmodule

bind set_associative_lru_cache_sim salc_chk u_salc_chk (.*);
